[design/ple_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_pkg: shared types and constants for the positional list engine
// Request and response beat layouts, opcode and status codes, defaults.
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int CAPACITY_DEF    = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int OPCODE_W = 2;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_INSERT = 2'd2,
        OP_DELETE = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef struct packed {
        t_opcode             opcode;
        logic [POS_W-1:0]    position;
        logic [DATA_W-1:0]   value;
    } t_req;

    typedef struct packed {
        logic [DATA_W-1:0]   read_value;
        t_status             status;
        logic [COUNT_W-1:0]  count;
        logic                is_empty;
    } t_rsp;

endpackage

[design/ple_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_stream_if: valid/ready channel carrying one payload beat
// A beat moves on a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface ple_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/ple_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_ram: element store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ple_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/positional_list_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine: bounded ordered list addressed by 1-based position
// Read, write, insert and delete over a compacted element store.
// ----------------------------------------------------------------------------
// One request beat in, one response beat out; the block takes the next
// request only after the response has been taken. Elements 1..count live in
// store slots 0..count-1 of a single-port-write, single-port-read RAM.
// A read goes through decode and a RAM read wait to the response; write and
// rejected requests go from decode straight to the response. Insert and
// delete move every element behind the position by one slot through the RAM,
// one element per cycle with the read of the next element overlapping the
// write of the previous one; an insert at the front of an almost full list
// moves CAPACITY - 1 elements. The RAM's one write port sets that rate. The
// store is never cleared; only slots below the count are ever read.
// ----------------------------------------------------------------------------
module positional_list_engine
    import ple_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ple_stream_if.sink    i_req,
    ple_stream_if.source  o_rsp
);

    localparam int AW = $clog2(CAPACITY);         // slot address
    localparam int CW = $clog2(CAPACITY + 1);     // element count
    localparam int PW = (CW > POS_W) ? CW : POS_W; // position compare width
    localparam int XW = (VALUE_WIDTH > DATA_W) ? VALUE_WIDTH : DATA_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RDWAIT,
        S_SHIFT,
        S_DRAIN,
        S_PUT,
        S_RESP
    } t_state;

    t_state                 r_state;
    t_opcode                r_op;
    logic [POS_W-1:0]       r_pos;
    logic [VALUE_WIDTH-1:0] r_val;
    logic [CW-1:0]          r_count;
    logic [AW-1:0]          r_slot;   // insert target slot
    logic [AW-1:0]          r_ptr;    // next slot to read during a move
    logic [AW-1:0]          r_end;    // last slot to read during a move
    logic [AW-1:0]          r_wa;     // write slot for the pending read data
    logic                   r_pend;   // read data waiting to be written
    logic [DATA_W-1:0]      r_rdval;
    t_status                r_status;

    // RAM controls
    logic                   w_wr_en;
    logic [AW-1:0]          w_wr_addr;
    logic [VALUE_WIDTH-1:0] w_wr_data;
    logic                   w_rd_en;
    logic [AW-1:0]          w_rd_addr;
    logic [VALUE_WIDTH-1:0] w_rd_data;

    // Decode helpers
    logic [PW-1:0]          w_pos_x;
    logic [PW-1:0]          w_cnt_x;
    logic                   w_pos_ok;
    logic                   w_full;
    logic [AW-1:0]          w_pos_addr;
    logic [AW-1:0]          w_ins_slot;
    logic [XW-1:0]          w_in_val_x;
    logic [XW-1:0]          w_rd_x;
    logic                   w_ins;

    assign w_pos_x    = PW'(r_pos);
    assign w_cnt_x    = PW'(r_count);
    assign w_pos_ok   = (w_pos_x != '0) && (w_pos_x <= w_cnt_x);
    assign w_full     = (r_count == CW'(CAPACITY));
    assign w_pos_addr = AW'(w_pos_x - PW'(1));
    assign w_in_val_x = XW'(i_req.data.value);
    assign w_rd_x     = XW'(w_rd_data);
    assign w_ins      = (r_op == OP_INSERT);

    // Front for position 0 or 1, append past the count, else before position
    always_comb begin
        if (w_pos_x <= PW'(1)) begin
            w_ins_slot = '0;
        end else if (w_pos_x > w_cnt_x) begin
            w_ins_slot = AW'(r_count);
        end else begin
            w_ins_slot = w_pos_addr;
        end
    end

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_wa;
        w_wr_data = w_rd_data;
        w_rd_en   = 1'b0;
        w_rd_addr = r_ptr;
        unique case (r_state)
            S_DECODE: begin
                if (r_op == OP_READ && w_pos_ok) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_pos_addr;
                end else if (r_op == OP_WRITE && w_pos_ok) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = w_pos_addr;
                    w_wr_data = r_val;
                end
            end
            // read the next element, write back the one read last cycle
            S_SHIFT: begin
                w_rd_en = 1'b1;
                w_wr_en = r_pend;
            end
            S_DRAIN: begin
                w_wr_en = 1'b1;
            end
            S_PUT: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_slot;
                w_wr_data = r_val;
            end
            default: begin
            end
        endcase
    end

    ple_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_WIDTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_op    <= i_req.data.opcode;
                        r_pos   <= i_req.data.position;
                        r_val   <= w_in_val_x[VALUE_WIDTH-1:0];
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_rdval  <= '0;
                    r_pend   <= 1'b0;
                    unique case (r_op)
                        OP_READ: begin
                            if (w_pos_ok) begin
                                r_status <= ST_DONE;
                                r_state  <= S_RDWAIT;
                            end else begin
                                r_status <= ST_INVALID;
                                r_state  <= S_RESP;
                            end
                        end
                        OP_WRITE: begin
                            r_status <= w_pos_ok ? ST_DONE : ST_INVALID;
                            r_state  <= S_RESP;
                        end
                        OP_INSERT: begin
                            if (w_full) begin
                                r_status <= ST_FULL;
                                r_state  <= S_RESP;
                            end else begin
                                r_status <= ST_DONE;
                                r_slot   <= w_ins_slot;
                                if (w_cnt_x > PW'(w_ins_slot)) begin
                                    r_ptr   <= AW'(r_count - CW'(1));
                                    r_end   <= w_ins_slot;
                                    r_state <= S_SHIFT;
                                end else begin
                                    r_state <= S_PUT;
                                end
                            end
                        end
                        OP_DELETE: begin
                            if (!w_pos_ok) begin
                                r_status <= ST_INVALID;
                                r_state  <= S_RESP;
                            end else begin
                                r_status <= ST_DONE;
                                if (w_pos_x < w_cnt_x) begin
                                    // move slots pos..count-1 down by one
                                    r_ptr   <= AW'(w_pos_x);
                                    r_end   <= AW'(r_count - CW'(1));
                                    r_state <= S_SHIFT;
                                end else begin
                                    r_count <= r_count - CW'(1);
                                    r_state <= S_RESP;
                                end
                            end
                        end
                        default: begin
                            r_status <= ST_DONE;
                            r_state  <= S_RESP;
                        end
                    endcase
                end
                S_RDWAIT: begin
                    r_rdval <= w_rd_x[DATA_W-1:0];
                    r_state <= S_RESP;
                end
                S_SHIFT: begin
                    r_pend <= 1'b1;
                    r_wa   <= w_ins ? AW'(r_ptr + AW'(1)) : AW'(r_ptr - AW'(1));
                    if (r_ptr == r_end) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_ptr <= w_ins ? AW'(r_ptr - AW'(1)) : AW'(r_ptr + AW'(1));
                    end
                end
                S_DRAIN: begin
                    r_pend <= 1'b0;
                    if (w_ins) begin
                        r_state <= S_PUT;
                    end else begin
                        r_count <= r_count - CW'(1);
                        r_state <= S_RESP;
                    end
                end
                S_PUT: begin
                    r_count <= r_count + CW'(1);
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    if (o_rsp.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready = (r_state == S_IDLE);

    assign o_rsp.valid           = (r_state == S_RESP);
    assign o_rsp.data.read_value = r_rdval;
    assign o_rsp.data.status     = r_status;
    assign o_rsp.data.count      = COUNT_W'(r_count);
    assign o_rsp.data.is_empty   = (r_count == '0);

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && r_status == ST_FULL) |-> w_full)
        else $error("full reported on a list that is not full");

    a_put_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not add one element");

    a_rdval_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && r_op != OP_READ) |-> (r_rdval == '0))
        else $error("read value set on a non-read request");

    a_move_no_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && w_wr_en) |-> (w_wr_addr != w_rd_addr))
        else $error("move writes the slot it is reading");

endmodule
